@@ hw/rtl/fls_pkg.sv @@
// Shared types, codes and helpers for the free-list slot allocator.
`default_nettype none

package fls_pkg;

   // Default pool capacity and register geometry.
   localparam int unsigned MAX_SLOTS_DEFAULT = 1024;
   localparam int unsigned POOL_W            = 11;
   localparam int unsigned POOL_RESET        = 1024;
   localparam int unsigned PADDR_W           = 3;
   localparam int unsigned PDATA_W           = 32;

   // Register indexes on the configuration port.
   localparam int unsigned REG_POOL_SIZE = 0;

   // Request operation codes.
   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_RANGE  = 2'd2;
   localparam logic [1:0] ST_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [9:0] slot_id;
   } fls_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [9:0] granted_id;
   } fls_rsp_type;

   // Pool initialization control from the register block to the engine.
   typedef struct packed {
      logic reinit;
      logic sweep;
   } fls_init_type;

   // A written pool size of zero means one; anything above capacity means capacity.
   function automatic logic [31:0] pool_clamp(input logic [POOL_W-1:0] value,
                                              input int unsigned max_slots);
      logic [31:0] v;
      begin
         v = 32'(value);
         if (v == 32'd0) v = 32'd1;
         if (v > max_slots) v = max_slots;
         return v;
      end
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fls_ram.sv @@
// Generic single-write, single-read RAM with registered read data (read-first).
`default_nettype none

module fls_ram #(
   parameter int unsigned WIDTH = 10,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hw/rtl/fls_csr.sv @@
// Configuration registers and the pool initialization sweep sequencer.
`default_nettype none

module fls_csr #(
   parameter int unsigned MAX_SLOTS = fls_pkg::MAX_SLOTS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [fls_pkg::PADDR_W-1:0]       paddr,
   input  wire logic [fls_pkg::PDATA_W-1:0]       pwdata,
   output logic      [fls_pkg::PDATA_W-1:0]       prdata,
   output logic                                   pready,
   output logic      [$clog2(MAX_SLOTS+1)-1:0]    pool_size,
   output logic      [$clog2(MAX_SLOTS)-1:0]      clr_idx,
   output fls_pkg::fls_init_type                  init
);

   import fls_pkg::*;

   localparam int unsigned AW = $clog2(MAX_SLOTS);
   localparam int unsigned CW = $clog2(MAX_SLOTS + 1);

   logic          reg_sel;
   logic          wr_pool;
   logic [CW-1:0] pool_ff,    pool_in;
   logic [AW-1:0] clr_idx_ff, clr_idx_in;
   logic          sweep_ff,   sweep_in;
   logic          reinit_ff,  reinit_in;

   // Register decode; every access completes without wait states.
   assign pready  = 1'b1;
   assign reg_sel = (32'(paddr[PADDR_W-1:2]) == REG_POOL_SIZE);
   assign wr_pool = psel & penable & pwrite & reg_sel;
   assign prdata  = reg_sel ? PDATA_W'(pool_ff) : '0;

   // A pool size write restarts the sweep over the new pool.
   always_comb begin
      pool_in    = pool_ff;
      clr_idx_in = clr_idx_ff;
      sweep_in   = sweep_ff;
      reinit_in  = wr_pool;
      if (wr_pool) begin
         pool_in    = CW'(pool_clamp(pwdata[POOL_W-1:0], MAX_SLOTS));
         clr_idx_in = '0;
         sweep_in   = 1'b1;
      end else if (sweep_ff) begin
         if (32'(clr_idx_ff) == 32'(pool_ff) - 32'd1) begin
            sweep_in = 1'b0;
         end else begin
            clr_idx_in = clr_idx_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff    <= CW'(pool_clamp(POOL_W'(POOL_RESET), MAX_SLOTS));
         clr_idx_ff <= '0;
         sweep_ff   <= 1'b1;
         reinit_ff  <= 1'b1;
      end else begin
         pool_ff    <= pool_in;
         clr_idx_ff <= clr_idx_in;
         sweep_ff   <= sweep_in;
         reinit_ff  <= reinit_in;
      end
   end

   assign pool_size   = pool_ff;
   assign clr_idx     = clr_idx_ff;
   assign init.reinit = reinit_ff;
   assign init.sweep  = sweep_ff;

endmodule

`default_nettype wire

@@ hw/rtl/fls_engine.sv @@
// Request stage: free stack and in-use memories, stack count and result register.
`default_nettype none

module fls_engine #(
   parameter int unsigned MAX_SLOTS = fls_pkg::MAX_SLOTS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire fls_pkg::fls_req_type           req_data,
   input  wire logic [$clog2(MAX_SLOTS+1)-1:0] pool_size,
   input  wire logic [$clog2(MAX_SLOTS)-1:0]   clr_idx,
   input  wire fls_pkg::fls_init_type          init,
   output logic                                rsp_valid,
   output fls_pkg::fls_rsp_type                rsp_data
);

   import fls_pkg::*;

   localparam int unsigned AW = $clog2(MAX_SLOTS);
   localparam int unsigned CW = $clog2(MAX_SLOTS + 1);

   // Stage and output registers.
   logic          stg_valid_ff;
   logic [1:0]    stg_func_ff;
   logic [9:0]    stg_id_ff;
   logic [CW-1:0] count_ff, count_in;
   logic          stk_hit_ff, stk_hit_in;
   logic [AW-1:0] stk_byp_ff;
   logic          use_hit_ff, use_hit_in;
   logic          use_byp_ff;
   logic          rsp_valid_ff;
   fls_rsp_type   rsp_data_ff, rsp_data_in;

   // Stage-side memory accesses.
   logic          stk_we;
   logic [AW-1:0] stk_waddr, stk_wdata;
   logic          use_we;
   logic [AW-1:0] use_waddr;
   logic          use_wdata;

   // Memory ports after the sweep mux.
   logic          stk_ram_we, use_ram_we;
   logic [AW-1:0] stk_ram_waddr, stk_ram_wdata, use_ram_waddr;
   logic [0:0]    use_ram_wdata;
   logic [AW-1:0] stk_raddr, use_raddr;
   logic [AW-1:0] stk_rdata;
   logic [0:0]    use_rdata;

   logic [AW-1:0] stk_val;
   logic          use_val;
   logic          in_range;

   // Read data, patched with the write that landed on the same edge as the read.
   assign stk_val  = stk_hit_ff ? stk_byp_ff : stk_rdata;
   assign use_val  = use_hit_ff ? use_byp_ff : use_rdata[0];
   assign in_range = (32'(stg_id_ff) < 32'(pool_size));

   // Decode the staged request and work out its result and state updates.
   always_comb begin
      rsp_data_in.status     = ST_OK;
      rsp_data_in.granted_id = stg_id_ff;
      count_in               = count_ff;
      stk_we                 = 1'b0;
      stk_waddr              = AW'(count_ff);
      stk_wdata              = AW'(stg_id_ff);
      use_we                 = 1'b0;
      use_waddr              = AW'(stg_id_ff);
      use_wdata              = 1'b0;
      unique case (stg_func_ff)
         FUNC_ALLOC: begin
            if (count_ff == '0) begin
               rsp_data_in.status     = ST_EMPTY;
               rsp_data_in.granted_id = '0;
            end else begin
               rsp_data_in.granted_id = 10'(stk_val);
               count_in               = count_ff - CW'(1);
               use_we                 = stg_valid_ff;
               use_waddr              = stk_val;
               use_wdata              = 1'b1;
            end
         end
         FUNC_FREE: begin
            if (!in_range) begin
               rsp_data_in.status = ST_RANGE;
            end else if (!use_val) begin
               rsp_data_in.status = ST_UNUSED;
            end else if (32'(count_ff) < MAX_SLOTS) begin
               count_in = count_ff + CW'(1);
               stk_we   = stg_valid_ff;
               use_we   = stg_valid_ff;
            end
         end
         default: begin
            if (!in_range) begin
               rsp_data_in.status = ST_RANGE;
            end else if (!use_val) begin
               rsp_data_in.status = ST_UNUSED;
            end
         end
      endcase
      if (!stg_valid_ff) begin
         count_in = count_ff;
      end
      if (init.reinit) begin
         count_in = pool_size;
      end
   end

   // The sweep owns the write ports while the pool is being rebuilt.
   always_comb begin
      if (init.sweep) begin
         stk_ram_we    = 1'b1;
         stk_ram_waddr = clr_idx;
         stk_ram_wdata = clr_idx;
         use_ram_we    = 1'b1;
         use_ram_waddr = clr_idx;
         use_ram_wdata = 1'b0;
      end else begin
         stk_ram_we    = stk_we;
         stk_ram_waddr = stk_waddr;
         stk_ram_wdata = stk_wdata;
         use_ram_we    = use_we;
         use_ram_waddr = use_waddr;
         use_ram_wdata = use_wdata;
      end
   end

   // Reads for the incoming request use the count as this edge leaves it.
   assign stk_raddr  = AW'(count_in - CW'(1));
   assign use_raddr  = AW'(req_data.slot_id);
   assign stk_hit_in = stk_ram_we && (stk_ram_waddr == stk_raddr);
   assign use_hit_in = use_ram_we && (use_ram_waddr == use_raddr);

   fls_ram #(
      .WIDTH (AW),
      .DEPTH (MAX_SLOTS)
   ) u_stack_ram (
      .clock (clock),
      .we    (stk_ram_we),
      .waddr (stk_ram_waddr),
      .wdata (stk_ram_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   fls_ram #(
      .WIDTH (1),
      .DEPTH (MAX_SLOTS)
   ) u_use_ram (
      .clock (clock),
      .we    (use_ram_we),
      .waddr (use_ram_waddr),
      .wdata (use_ram_wdata),
      .raddr (use_raddr),
      .rdata (use_rdata)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         stg_valid_ff <= accept;
         rsp_valid_ff <= stg_valid_ff;
         count_ff     <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         stg_func_ff <= req_data.func;
         stg_id_ff   <= req_data.slot_id;
      end
      stk_hit_ff  <= stk_hit_in;
      stk_byp_ff  <= stk_ram_wdata;
      use_hit_ff  <= use_hit_in;
      use_byp_ff  <= use_ram_wdata[0];
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/free_list_slot_allocator.sv @@
// Top level of the free-list slot allocator.
//
// Requests (allocate, free, query) enter on start/req_data and are taken at
// any clock edge where start is high and busy is low. One request can be
// taken every cycle while busy is low. Each request gives exactly one result:
// rsp_valid is high for one cycle with rsp_data, starting at the first clock
// edge after the request was taken (the memory read happens on the accepting
// edge, the result register loads next). The receiver cannot stall; results
// must be consumed as they appear. Allocate pops the top of the free stack,
// free pushes a slot back after a range and in-use check, and query reports
// range and in-use status. The pool size register sits at byte address 0 of
// the APB-style port. After reset, and after each pool size write, a sweep
// rewrites the free stack and clears the in-use memory, one entry per cycle,
// over pool_size entries (1024 after reset); busy is high during the sweep
// and register writes are still taken. The user must write pool size only
// while no request is open; the block itself does not enforce this.
`default_nettype none

module free_list_slot_allocator #(
   parameter int unsigned MAX_SLOTS = fls_pkg::MAX_SLOTS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire fls_pkg::fls_req_type        req_data,
   output logic                             rsp_valid,
   output fls_pkg::fls_rsp_type             rsp_data,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [fls_pkg::PADDR_W-1:0] paddr,
   input  wire logic [fls_pkg::PDATA_W-1:0] pwdata,
   output logic      [fls_pkg::PDATA_W-1:0] prdata,
   output logic                             pready
);

   import fls_pkg::*;

   localparam int unsigned AW = $clog2(MAX_SLOTS);
   localparam int unsigned CW = $clog2(MAX_SLOTS + 1);

   logic [CW-1:0] pool_size;
   logic [AW-1:0] clr_idx;
   fls_init_type  init;
   logic          accept;

   // Requests are held off only while the pool is being rebuilt.
   assign busy   = init.sweep;
   assign accept = start & ~busy;

   fls_csr #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .pool_size (pool_size),
      .clr_idx   (clr_idx),
      .init      (init)
   );

   fls_engine #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .pool_size (pool_size),
      .clr_idx   (clr_idx),
      .init      (init),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ tb/tb_free_list_slot_allocator.sv @@
// Self-checking testbench for the free-list slot allocator top level.
`timescale 1ns / 1ps

module tb_free_list_slot_allocator;
   import fls_pkg::*;

   localparam int SLOT_CAP = MAX_SLOTS_DEFAULT;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   fls_req_type         req_data = '0;
   logic                rsp_valid;
   fls_rsp_type         rsp_data;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [PADDR_W-1:0]  paddr = '0;
   logic [PDATA_W-1:0]  pwdata = '0;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   // Shadow of the allocator state, advanced once per accepted request.
   int          pool_slots;
   logic [9:0]  slot_stack [SLOT_CAP];
   int          stack_depth;
   bit          slot_busy [SLOT_CAP];
   logic [9:0]  held_slots [$];
   fls_rsp_type awaited_results [$];

   int mismatches = 0;
   int requests_sent = 0;
   int results_checked = 0;
   int pool_writes = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   free_list_slot_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   // Refill the shadow stack with ascending ids and clear every in-use bit.
   task automatic refill_pool(input int size);
      for (int i = 0; i < size; i++) slot_stack[i] = 10'(i);
      for (int i = 0; i < SLOT_CAP; i++) slot_busy[i] = 1'b0;
      pool_slots  = size;
      stack_depth = size;
      held_slots.delete();
   endtask

   // Work out the result of one request and update the shadow state.
   function automatic fls_rsp_type compute_slot_result(input fls_req_type item);
      fls_rsp_type outcome;
      int          hits [$];
      outcome.status     = ST_OK;
      outcome.granted_id = item.slot_id;
      if (item.func == FUNC_ALLOC) begin
         if (stack_depth == 0) begin
            outcome.status     = ST_EMPTY;
            outcome.granted_id = '0;
         end else begin
            stack_depth--;
            outcome.granted_id = slot_stack[stack_depth];
            slot_busy[outcome.granted_id] = 1'b1;
            held_slots.push_back(outcome.granted_id);
         end
      end else if (int'(item.slot_id) >= pool_slots) begin
         outcome.status = ST_RANGE;
      end else if (!slot_busy[item.slot_id]) begin
         outcome.status = ST_UNUSED;
      end else if (item.func == FUNC_FREE && stack_depth < SLOT_CAP) begin
         // Only a free releases the slot; a query with either selector leaves it held.
         slot_busy[item.slot_id] = 1'b0;
         slot_stack[stack_depth] = item.slot_id;
         stack_depth++;
         hits = held_slots.find_first_index(s) with (s == item.slot_id);
         if (hits.size() > 0) held_slots.delete(hits[0]);
      end
      return outcome;
   endfunction

   task automatic note_mismatch(input string field, input int want, input int got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: mismatch on %s: expected %0d, got %0d", $time, field, want, got);
   endtask

   // Check every result against the oldest outstanding expectation.
   always @(posedge clock) begin : result_check
      fls_rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            note_mismatch("unexpected result status", -1, int'(rsp_data.status));
         end else begin
            want = awaited_results.pop_front();
            results_checked++;
            status_seen[rsp_data.status]++;
            if (rsp_data.status !== want.status)
               note_mismatch("status", int'(want.status), int'(rsp_data.status));
            if (rsp_data.granted_id !== want.granted_id)
               note_mismatch("granted_id", int'(want.granted_id),
                             int'(rsp_data.granted_id));
         end
      end
   end

   // Present one request and hold it until the block takes it.
   task automatic send_request(input logic [1:0] func, input logic [9:0] id);
      fls_req_type item;
      item.func    = func;
      item.slot_id = id;
      @(negedge clock);
      start    = 1'b1;
      req_data = item;
      do @(posedge clock); while (busy);
      awaited_results.push_back(compute_slot_result(item));
      requests_sent++;
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Mostly back to back, sometimes a short pause, now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Stop sending and wait until every outstanding request has its result.
   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      while (awaited_results.size() > 0) @(posedge clock);
   endtask

   // Write the pool size over the register port while no request is open.
   task automatic write_pool_size(input logic [31:0] value);
      int size;
      drain_results();
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = PADDR_W'(REG_POOL_SIZE * 4);
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      // Only the low 11 bits count; zero means one and oversize means capacity.
      size = int'(value[POOL_W-1:0]);
      if (size == 0) size = 1;
      if (size > SLOT_CAP) size = SLOT_CAP;
      refill_pool(size);
      pool_writes++;
      // Let the refill sweep raise busy before the next request goes out.
      for (int i = 0; i < 4; i++) begin
         @(posedge clock);
         if (busy) break;
      end
   endtask

   // Fresh pool after reset: unused slots, the top of the stack, double free.
   task automatic test_reset_pool();
      send_request(FUNC_QUERY, 10'd0);
      send_request(FUNC_QUERY, 10'd1023);
      send_request(FUNC_FREE, 10'd5);
      send_request(FUNC_ALLOC, 10'd1023);
      send_request(FUNC_ALLOC, 10'd0);
      send_request(FUNC_QUERY, 10'd1023);
      // Selector with both bits set acts as a query.
      send_request(FUNC_QUERY | FUNC_FREE, 10'd1022);
      send_request(FUNC_FREE, 10'd1023);
      send_request(FUNC_FREE, 10'd1023);
      send_request(FUNC_ALLOC, 10'd512);
   endtask

   // Smallest pools, the empty pool, out-of-range ids and clamped sizes.
   task automatic test_pool_limits();
      write_pool_size(32'd0);
      send_request(FUNC_ALLOC, 10'd0);
      send_request(FUNC_ALLOC, 10'd1023);
      send_request(FUNC_QUERY, 10'd1);
      send_request(FUNC_FREE, 10'd0);
      send_request(FUNC_QUERY | FUNC_FREE, 10'd0);
      write_pool_size(32'd2);
      send_request(FUNC_ALLOC, 10'd0);
      send_request(FUNC_ALLOC, 10'd0);
      send_request(FUNC_ALLOC, 10'd0);
      send_request(FUNC_FREE, 10'd2);
      send_request(FUNC_FREE, 10'd1023);
      write_pool_size(32'h0000_07FF);
      send_request(FUNC_QUERY, 10'd1023);
      send_request(FUNC_ALLOC, 10'd0);
   endtask

   // Random allocate and free traffic on one pool size.
   task automatic run_traffic_phase(input logic [31:0] pool_value, input int count,
                                    input int alloc_pct, input bit no_gaps);
      int         r;
      logic [1:0] func;
      logic [9:0] id;
      write_pool_size(pool_value);
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < alloc_pct) begin
            func = FUNC_ALLOC;
            id   = 10'($urandom_range(1023));
         end else if (r < alloc_pct + 25 && held_slots.size() > 0) begin
            func = FUNC_FREE;
            id   = held_slots[$urandom_range(held_slots.size() - 1)];
         end else begin
            // Stray request: any selector, id inside the pool or anywhere.
            func = 2'($urandom_range(3));
            id   = $urandom_range(1) ? 10'($urandom_range(pool_slots - 1))
                                     : 10'($urandom_range(1023));
         end
         send_request(func, id);
         if (n == count / 2) drain_results();
         else if (!no_gaps) idle_for(gap_length());
      end
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(32'd1024, 200, 45, 1'b0);
      run_traffic_phase(32'($urandom_range(64, 3)), 200, 55, 1'b0);
      run_traffic_phase(32'd1, 100, 40, 1'b0);
      run_traffic_phase(32'd2, 100, 45, 1'b0);
      run_traffic_phase(32'($urandom_range(1023, 100)), 200, 50, 1'b1);
      run_traffic_phase(32'd1500, 230, 70, 1'b0);
   endtask

   initial begin
      refill_pool(int'(POOL_RESET));
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_reset_pool();
      test_pool_limits();
      test_random_traffic();
      drain_results();
      repeat (8) @(posedge clock);
      $display("Sent %0d requests over %0d pool size writes; checked %0d results.",
               requests_sent, pool_writes, results_checked);
      $display("Status mix: ok %0d, empty %0d, out of range %0d, not in use %0d.",
               status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_RANGE],
               status_seen[ST_UNUSED]);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("free_list_slot_allocator test passed");
      end else begin
         $display("free_list_slot_allocator test failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #10_000_000;
      $display("free_list_slot_allocator test failed");
      $finish;
   end

endmodule
